@@ src/ssf_pkg.sv @@
// ----------------------------------------------------------------------------
// ssf_pkg
// Types and constants shared by the safety supervisor: supervisor states,
// item function codes, error bit positions and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package ssf_pkg;

   // supervisor state, encoding matches the safety_state result field
   typedef enum logic [1:0] {
      ST_NORMAL  = 2'd0,
      ST_WARNING = 2'd1,
      ST_ERROR   = 2'd2,
      ST_SAFE    = 2'd3
   } mode_type;

   // item function codes
   typedef enum logic [2:0] {
      FN_TICK    = 3'd0,
      FN_REFRESH = 3'd1,
      FN_TEMP    = 3'd2,
      FN_VOLT    = 3'd3,
      FN_CURRENT = 3'd4,
      FN_CLEAR   = 3'd5,
      FN_STATS   = 3'd6,
      FN_UNUSED  = 3'd7
   } func_type;

   typedef logic [6:0] err_type;

   localparam err_type E_WDG   = 7'h01;
   localparam err_type E_TLOW  = 7'h02;
   localparam err_type E_THIGH = 7'h04;
   localparam err_type E_VLOW  = 7'h08;
   localparam err_type E_VHIGH = 7'h10;
   localparam err_type E_OVC   = 7'h20;
   localparam err_type E_SEQ   = 7'h40;

   // register indexes on the csr port
   typedef logic [2:0] csr_idx_type;

   localparam csr_idx_type R_CHECK_EN   = 3'd0;
   localparam csr_idx_type R_WDG_TMO    = 3'd1;
   localparam csr_idx_type R_SAFE_TMO   = 3'd2;
   localparam csr_idx_type R_TEMP_LO    = 3'd3;
   localparam csr_idx_type R_TEMP_HI    = 3'd4;
   localparam csr_idx_type R_VOLT_LO    = 3'd5;
   localparam csr_idx_type R_VOLT_HI    = 3'd6;
   localparam csr_idx_type R_CURR_LIMIT = 3'd7;

   localparam logic [31:0] REFRESH_MIN_TICKS = 32'd10;
   localparam logic [31:0] RANGE_ERROR_LIMIT = 32'd10;

endpackage

`default_nettype wire

@@ src/safety_supervisor_fsm_unit.sv @@
// ----------------------------------------------------------------------------
// safety_supervisor_fsm_unit
// Safety supervisor: normal / warning / error / safe states, sticky error
// mask, millisecond time base, watchdog and sample range checks, statistics.
//
//   channel  dir  handshake            payload
//   req      in   req_valid/req_stall  req_func, req_sample, req_clear_mask
//   rsp      out  rsp_valid/rsp_stall  rsp_status ... rsp_refresh_count
//   csr      in   csr_write_en         csr_index, csr_data
//
// One item per cycle sustained while rsp is not stalled. An item is processed
// in the input register; its result is loaded into the result register, from
// which rsp takes it. Synchronous reset clears the state and counters and
// loads the register defaults. A stall on rsp holds the result register, and
// the input register then stalls req once it holds an item.
// ----------------------------------------------------------------------------
`default_nettype none

module safety_supervisor_fsm_unit (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [2:0]           req_func,
   input  wire logic signed [31:0]   req_sample,
   input  wire logic [6:0]           req_clear_mask,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic                      rsp_status,
   output logic [1:0]                rsp_safety_state,
   output logic [6:0]                rsp_error_bits,
   output logic [31:0]               rsp_range_error_count,
   output logic [31:0]               rsp_total_error_count,
   output logic [31:0]               rsp_safe_entry_count,
   output logic [31:0]               rsp_refresh_count,
   input  wire logic                 csr_write_en,
   input  wire ssf_pkg::csr_idx_type csr_index,
   input  wire logic [31:0]          csr_data
);

   import ssf_pkg::*;

   // configuration
   logic [1:0]         check_en_ff;
   logic [31:0]        wdg_tmo_ff;
   logic [31:0]        safe_tmo_ff;
   logic signed [15:0] temp_lo_ff;
   logic signed [15:0] temp_hi_ff;
   logic [15:0]        volt_lo_ff;
   logic [15:0]        volt_hi_ff;
   logic [30:0]        curr_limit_ff;

   // input register
   logic               in_valid_ff;
   logic [2:0]         in_func_ff;
   logic signed [31:0] in_sample_ff;
   logic [6:0]         in_cmask_ff;

   // supervisor state
   mode_type    mode_ff, mode_in;
   err_type     err_ff, err_in;
   logic [31:0] time_ff, time_in;
   logic [31:0] last_ref_ff, last_ref_in;
   logic [31:0] safe_time_ff, safe_time_in;
   logic [31:0] range_cnt_ff, range_cnt_in;
   logic [31:0] total_cnt_ff, total_cnt_in;
   logic [31:0] safe_cnt_ff, safe_cnt_in;
   logic [31:0] ref_cnt_ff, ref_cnt_in;
   logic        status_in;

   // result register
   logic        out_valid_ff;
   logic        out_status_ff;
   logic [1:0]  out_state_ff;
   logic [6:0]  out_err_ff;
   logic [31:0] out_range_ff;
   logic [31:0] out_total_ff;
   logic [31:0] out_safe_ff;
   logic [31:0] out_ref_ff;

   logic advance;
   logic take_req;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign take_req  = req_valid && !req_stall;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         check_en_ff   <= 2'd3;
         wdg_tmo_ff    <= 32'd1000;
         safe_tmo_ff   <= 32'd5000;
         temp_lo_ff    <= -16'sd40;
         temp_hi_ff    <= 16'sd85;
         volt_lo_ff    <= 16'd9000;
         volt_hi_ff    <= 16'd16000;
         curr_limit_ff <= 31'd10000;
      end else if (csr_write_en) begin
         unique case (csr_index)
            R_CHECK_EN:   check_en_ff   <= csr_data[1:0];
            R_WDG_TMO:    wdg_tmo_ff    <= csr_data;
            R_SAFE_TMO:   safe_tmo_ff   <= csr_data;
            R_TEMP_LO:    temp_lo_ff    <= $signed(csr_data[15:0]);
            R_TEMP_HI:    temp_hi_ff    <= $signed(csr_data[15:0]);
            R_VOLT_LO:    volt_lo_ff    <= csr_data[15:0];
            R_VOLT_HI:    volt_hi_ff    <= csr_data[15:0];
            R_CURR_LIMIT: curr_limit_ff <= csr_data[30:0];
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (take_req) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_func_ff   <= FN_TICK;
         in_sample_ff <= '0;
         in_cmask_ff  <= '0;
      end else if (take_req) begin
         in_func_ff   <= req_func;
         in_sample_ff <= req_sample;
         in_cmask_ff  <= req_clear_mask;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= ST_NORMAL;
         err_ff       <= '0;
         time_ff      <= '0;
         last_ref_ff  <= '0;
         safe_time_ff <= '0;
         range_cnt_ff <= '0;
         total_cnt_ff <= '0;
         safe_cnt_ff  <= '0;
         ref_cnt_ff   <= '0;
      end else if (advance) begin
         mode_ff      <= mode_in;
         err_ff       <= err_in;
         time_ff      <= time_in;
         last_ref_ff  <= last_ref_in;
         safe_time_ff <= safe_time_in;
         range_cnt_ff <= range_cnt_in;
         total_cnt_ff <= total_cnt_in;
         safe_cnt_ff  <= safe_cnt_in;
         ref_cnt_ff   <= ref_cnt_in;
      end
   end

   // item processing, next state and result
   always_comb begin
      logic [31:0]        time_inc;
      logic               range_on;
      logic signed [31:0] temp_lo_ext;
      logic signed [31:0] temp_hi_ext;
      logic signed [31:0] volt_lo_ext;
      logic signed [31:0] volt_hi_ext;
      logic [31:0]        mag;
      err_type            err_cleared;
      logic               fault;

      time_inc    = time_ff + 32'd1;
      range_on    = check_en_ff[1];
      temp_lo_ext = 32'(temp_lo_ff);
      temp_hi_ext = 32'(temp_hi_ff);
      volt_lo_ext = $signed({16'd0, volt_lo_ff});
      volt_hi_ext = $signed({16'd0, volt_hi_ff});
      mag         = in_sample_ff[31] ? (32'd0 - in_sample_ff) : in_sample_ff;
      err_cleared = err_ff & ~in_cmask_ff;
      fault       = 1'b0;

      mode_in      = mode_ff;
      err_in       = err_ff;
      time_in      = time_ff;
      last_ref_in  = last_ref_ff;
      safe_time_in = safe_time_ff;
      range_cnt_in = range_cnt_ff;
      total_cnt_in = total_cnt_ff;
      safe_cnt_in  = safe_cnt_ff;
      ref_cnt_in   = ref_cnt_ff;
      status_in    = 1'b0;

      unique case (func_type'(in_func_ff))
         FN_TICK: begin
            time_in = time_inc;
            priority if (check_en_ff[0] && (time_inc - last_ref_ff) > wdg_tmo_ff) begin
               total_cnt_in = total_cnt_ff + 32'd1;
               err_in       = err_ff | E_WDG;
               safe_time_in = time_inc;
               mode_in      = ST_SAFE;
               safe_cnt_in  = safe_cnt_ff + 32'd1;
               status_in    = 1'b1;
            end else if (range_cnt_ff >= RANGE_ERROR_LIMIT) begin
               safe_time_in = time_inc;
               mode_in      = ST_SAFE;
               safe_cnt_in  = safe_cnt_ff + 32'd1;
               status_in    = 1'b1;
            end else if ((mode_ff == ST_ERROR || mode_ff == ST_SAFE)
                         && (time_inc - safe_time_ff) > safe_tmo_ff
                         && err_ff == '0) begin
               mode_in = ST_NORMAL;
            end else begin
               mode_in = mode_ff;
            end
         end
         FN_REFRESH: begin
            if ((time_ff - last_ref_ff) < REFRESH_MIN_TICKS) begin
               total_cnt_in = total_cnt_ff + 32'd1;
               err_in       = err_ff | E_SEQ;
               if (mode_ff == ST_NORMAL) begin
                  mode_in = ST_ERROR;
               end
               status_in = 1'b1;
            end else begin
               last_ref_in = time_ff;
               ref_cnt_in  = ref_cnt_ff + 32'd1;
            end
         end
         FN_TEMP, FN_VOLT, FN_CURRENT: begin
            if (range_on) begin
               // pick the failing limit, if any
               priority if (in_func_ff == FN_TEMP && in_sample_ff < temp_lo_ext) begin
                  err_in = err_ff | E_TLOW;
                  fault  = 1'b1;
               end else if (in_func_ff == FN_TEMP && in_sample_ff > temp_hi_ext) begin
                  err_in = err_ff | E_THIGH;
                  fault  = 1'b1;
               end else if (in_func_ff == FN_VOLT && in_sample_ff < volt_lo_ext) begin
                  err_in = err_ff | E_VLOW;
                  fault  = 1'b1;
               end else if (in_func_ff == FN_VOLT && in_sample_ff > volt_hi_ext) begin
                  err_in = err_ff | E_VHIGH;
                  fault  = 1'b1;
               end else if (in_func_ff == FN_CURRENT && mag > {1'b0, curr_limit_ff}) begin
                  err_in = err_ff | E_OVC;
                  fault  = 1'b1;
               end else begin
                  err_in = err_ff;
                  fault  = 1'b0;
               end
               if (fault) begin
                  status_in    = 1'b1;
                  range_cnt_in = range_cnt_ff + 32'd1;
                  total_cnt_in = total_cnt_ff + 32'd1;
                  if (mode_ff == ST_NORMAL) begin
                     mode_in = (in_func_ff == FN_VOLT) ? ST_ERROR : ST_WARNING;
                  end
               end
            end
         end
         FN_CLEAR: begin
            err_in = err_cleared;
            if (err_cleared == '0) begin
               mode_in = ST_NORMAL;
            end
         end
         FN_STATS: begin
            range_cnt_in = '0;
            total_cnt_in = '0;
            safe_cnt_in  = '0;
            ref_cnt_in   = '0;
         end
         FN_UNUSED: begin
            status_in = 1'b1;
         end
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_status_ff <= status_in;
         out_state_ff  <= mode_in;
         out_err_ff    <= err_in;
         out_range_ff  <= range_cnt_in;
         out_total_ff  <= total_cnt_in;
         out_safe_ff   <= safe_cnt_in;
         out_ref_ff    <= ref_cnt_in;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_status            = out_status_ff;
   assign rsp_safety_state      = out_state_ff;
   assign rsp_error_bits        = out_err_ff;
   assign rsp_range_error_count = out_range_ff;
   assign rsp_total_error_count = out_total_ff;
   assign rsp_safe_entry_count  = out_safe_ff;
   assign rsp_refresh_count     = out_ref_ff;

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the safety supervisor. A driver sends words from a queue and
// predicts each result as the word is taken; a monitor checks every result
// word, field by field, against the oldest prediction. The run walks through
// several register settings and sender / receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ssf_pkg::*;

   typedef struct {
      func_type           fn;
      logic signed [31:0] smp;
      logic [6:0]         cmask;
   } supv_item_type;

   typedef struct {
      logic        status;
      mode_type    state;
      err_type     errs;
      logic [31:0] range_n;
      logic [31:0] total_n;
      logic [31:0] safe_n;
      logic [31:0] refresh_n;
   } supv_report_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [2:0]          req_func = '0;
   logic signed [31:0]  req_sample = '0;
   logic [6:0]          req_clear_mask = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_status;
   logic [1:0]          rsp_safety_state;
   logic [6:0]          rsp_error_bits;
   logic [31:0]         rsp_range_error_count;
   logic [31:0]         rsp_total_error_count;
   logic [31:0]         rsp_safe_entry_count;
   logic [31:0]         rsp_refresh_count;
   logic                csr_write_en = 1'b0;
   csr_idx_type         csr_index = R_CHECK_EN;
   logic [31:0]         csr_data = '0;

   safety_supervisor_fsm_unit dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_func              (req_func),
      .req_sample            (req_sample),
      .req_clear_mask        (req_clear_mask),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (rsp_status),
      .rsp_safety_state      (rsp_safety_state),
      .rsp_error_bits        (rsp_error_bits),
      .rsp_range_error_count (rsp_range_error_count),
      .rsp_total_error_count (rsp_total_error_count),
      .rsp_safe_entry_count  (rsp_safe_entry_count),
      .rsp_refresh_count     (rsp_refresh_count),
      .csr_write_en          (csr_write_en),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // supervisor register copy, reset values
   logic [1:0]         cfg_checks   = 2'd3;
   logic [31:0]        cfg_wdg_tmo  = 32'd1000;
   logic [31:0]        cfg_safe_tmo = 32'd5000;
   logic signed [15:0] cfg_temp_lo  = -16'sd40;
   logic signed [15:0] cfg_temp_hi  = 16'sd85;
   logic [15:0]        cfg_volt_lo  = 16'd9000;
   logic [15:0]        cfg_volt_hi  = 16'd16000;
   logic [30:0]        cfg_curr_lim = 31'd10000;

   // supervisor state copy
   mode_type    mode         = ST_NORMAL;
   err_type     err_mask     = '0;
   logic [31:0] now_ms       = '0;
   logic [31:0] last_refresh = '0;
   logic [31:0] safe_since   = '0;
   logic [31:0] range_n      = '0;
   logic [31:0] total_n      = '0;
   logic [31:0] safe_n       = '0;
   logic [31:0] refresh_n    = '0;

   supv_item_type   queued_items[$];
   supv_report_type expected_reports[$];
   int              send_idle_pct = 0;
   int              recv_stall_pct = 0;
   logic            pressure_go = 1'b0;
   logic            rcv_hold = 1'b0;
   int              mismatch_count = 0;

   function automatic void enter_safe();
      safe_since = now_ms;
      mode = ST_SAFE;
      safe_n++;
   endfunction

   // watchdog goes to safe, temp and overcurrent warn, the rest are errors
   function automatic void flag_error(err_type err_bit);
      err_mask |= err_bit;
      if (err_bit == E_WDG) begin
         enter_safe();
      end else if (err_bit == E_OVC || err_bit == E_THIGH || err_bit == E_TLOW) begin
         if (mode == ST_NORMAL) mode = ST_WARNING;
      end else begin
         if (mode == ST_NORMAL) mode = ST_ERROR;
      end
   endfunction

   function automatic void count_range_fault(err_type err_bit);
      range_n++;
      total_n++;
      flag_error(err_bit);
   endfunction

   function automatic supv_report_type supervise_item(supv_item_type it);
      supv_report_type r;
      logic [31:0]     mag;
      r.status = 1'b0;
      case (it.fn)
         FN_TICK: begin
            now_ms++;
            if (cfg_checks[0] && (now_ms - last_refresh) > cfg_wdg_tmo) begin
               total_n++;
               flag_error(E_WDG);
               r.status = 1'b1;
            end else if (range_n >= RANGE_ERROR_LIMIT) begin
               enter_safe();
               r.status = 1'b1;
            end else if ((mode == ST_ERROR || mode == ST_SAFE) &&
                         (now_ms - safe_since) > cfg_safe_tmo && err_mask == '0) begin
               mode = ST_NORMAL;
            end
         end
         FN_REFRESH: begin
            if ((now_ms - last_refresh) < REFRESH_MIN_TICKS) begin
               total_n++;
               flag_error(E_SEQ);
               r.status = 1'b1;
            end else begin
               last_refresh = now_ms;
               refresh_n++;
            end
         end
         FN_TEMP: begin
            if (cfg_checks[1]) begin
               if (it.smp < cfg_temp_lo) begin
                  count_range_fault(E_TLOW);
                  r.status = 1'b1;
               end else if (it.smp > cfg_temp_hi) begin
                  count_range_fault(E_THIGH);
                  r.status = 1'b1;
               end
            end
         end
         FN_VOLT: begin
            if (cfg_checks[1]) begin
               if (it.smp < $signed({16'h0, cfg_volt_lo})) begin
                  count_range_fault(E_VLOW);
                  r.status = 1'b1;
               end else if (it.smp > $signed({16'h0, cfg_volt_hi})) begin
                  count_range_fault(E_VHIGH);
                  r.status = 1'b1;
               end
            end
         end
         FN_CURRENT: begin
            if (cfg_checks[1]) begin
               // magnitude of the most negative sample wraps to 2^31
               mag = it.smp[31] ? 32'd0 - it.smp : it.smp;
               if (mag > {1'b0, cfg_curr_lim}) begin
                  count_range_fault(E_OVC);
                  r.status = 1'b1;
               end
            end
         end
         FN_CLEAR: begin
            err_mask &= ~it.cmask;
            if (err_mask == '0) mode = ST_NORMAL;
         end
         FN_STATS: begin
            range_n = '0;
            total_n = '0;
            safe_n = '0;
            refresh_n = '0;
         end
         default: r.status = 1'b1;
      endcase
      r.state = mode;
      r.errs = err_mask;
      r.range_n = range_n;
      r.total_n = total_n;
      r.safe_n = safe_n;
      r.refresh_n = refresh_n;
      return r;
   endfunction

   function automatic supv_item_type gen_item();
      supv_item_type it;
      int            pick;
      int            lim_lo;
      int            lim_hi;
      int            off;
      pick = $urandom_range(99);
      it.smp = $urandom;
      it.cmask = 7'($urandom_range(127));
      if (pick < 36) it.fn = FN_TICK;
      else if (pick < 46) it.fn = FN_REFRESH;
      else if (pick < 58) it.fn = FN_TEMP;
      else if (pick < 70) it.fn = FN_VOLT;
      else if (pick < 82) it.fn = FN_CURRENT;
      else if (pick < 91) it.fn = FN_CLEAR;
      else if (pick < 97) it.fn = FN_STATS;
      else it.fn = FN_UNUSED;
      case (it.fn)
         FN_TEMP: begin
            lim_lo = int'(cfg_temp_lo);
            lim_hi = int'(cfg_temp_hi);
         end
         FN_VOLT: begin
            lim_lo = int'(cfg_volt_lo);
            lim_hi = int'(cfg_volt_hi);
         end
         FN_CURRENT: begin
            lim_hi = int'(cfg_curr_lim);
            lim_lo = -lim_hi;
         end
         default: begin
            lim_lo = 0;
            lim_hi = 0;
         end
      endcase
      // mostly samples around the active limits
      pick = $urandom_range(9);
      off = int'($urandom_range(6)) - 3;
      if (pick < 3) begin
         it.smp = lim_lo + off;
      end else if (pick < 6) begin
         it.smp = lim_hi + off;
      end else if (pick == 7) begin
         case ($urandom_range(3))
            0: it.smp = 32'h8000_0000;
            1: it.smp = 32'h7FFF_FFFF;
            2: it.smp = 32'h0;
            default: it.smp = 32'hFFFF_FFFF;
         endcase
      end else if (pick > 7) begin
         it.smp = int'($urandom_range(200000)) - 100000;
      end
      if ($urandom_range(3) == 0) it.cmask = 7'h7F;
      return it;
   endfunction

   task automatic add_item(input func_type fn, input logic [31:0] smp, input logic [6:0] cmask);
      supv_item_type it;
      it.fn = fn;
      it.smp = smp;
      it.cmask = cmask;
      queued_items.push_back(it);
   endtask

   task automatic count_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%0t: %s", $realtime, msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      if (got_v !== want_v)
         count_failure($sformatf("%s mismatch: expected %0h, got %0h", name, want_v, got_v));
   endtask

   // driver: a word is taken at an edge with valid high and stall low
   always @(posedge clock) begin
      supv_item_type taken;
      supv_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            taken.fn = func_type'(req_func);
            taken.smp = req_sample;
            taken.cmask = req_clear_mask;
            expected_reports.push_back(supervise_item(taken));
         end
         if (!(req_valid && req_stall)) begin
            if (queued_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = queued_items.pop_front();
               req_valid <= 1'b1;
               req_func <= nxt.fn;
               req_sample <= nxt.smp;
               req_clear_mask <= nxt.cmask;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each result word against the oldest prediction
   always @(posedge clock) begin
      supv_report_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_reports.size() == 0) begin
               count_failure("result word with no prediction waiting");
            end else begin
               want = expected_reports.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_status));
               check_field("safety_state", 32'(want.state), 32'(rsp_safety_state));
               check_field("error_bits", 32'(want.errs), 32'(rsp_error_bits));
               check_field("range_error_count", want.range_n, rsp_range_error_count);
               check_field("total_error_count", want.total_n, rsp_total_error_count);
               check_field("safe_entry_count", want.safe_n, rsp_safe_entry_count);
               check_field("refresh_count", want.refresh_n, rsp_refresh_count);
            end
         end
         rsp_stall <= rcv_hold || ($urandom_range(99) < recv_stall_pct);
      end
   end

   // long receiver hold-off so the block backs up and stalls its input
   initial begin
      wait (pressure_go);
      rcv_hold = 1'b1;
      repeat (300) @(negedge clock);
      rcv_hold = 1'b0;
   end

   task automatic write_reg(input csr_idx_type idx, input logic [31:0] val);
      case (idx)
         R_CHECK_EN:   cfg_checks = val[1:0];
         R_WDG_TMO:    cfg_wdg_tmo = val;
         R_SAFE_TMO:   cfg_safe_tmo = val;
         R_TEMP_LO:    cfg_temp_lo = val[15:0];
         R_TEMP_HI:    cfg_temp_hi = val[15:0];
         R_VOLT_LO:    cfg_volt_lo = val[15:0];
         R_VOLT_HI:    cfg_volt_hi = val[15:0];
         default:      cfg_curr_lim = val[30:0];
      endcase
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic set_config(input logic [1:0] checks, input logic [31:0] wdg,
                             input logic [31:0] safe_tmo, input logic [15:0] tlo,
                             input logic [15:0] thi, input logic [15:0] vlo,
                             input logic [15:0] vhi, input logic [30:0] clim);
      write_reg(R_CHECK_EN, {30'h0, checks});
      write_reg(R_WDG_TMO, wdg);
      write_reg(R_SAFE_TMO, safe_tmo);
      write_reg(R_TEMP_LO, {{16{tlo[15]}}, tlo});
      write_reg(R_TEMP_HI, {{16{thi[15]}}, thi});
      write_reg(R_VOLT_LO, {16'h0, vlo});
      write_reg(R_VOLT_HI, {16'h0, vhi});
      write_reg(R_CURR_LIMIT, {1'b0, clim});
   endtask

   // wait for every queued word to be sent and every result to come back
   task automatic wait_drained();
      do @(negedge clock);
      while (queued_items.size() != 0 || req_valid || expected_reports.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic run_phase(input int n_items, input int idle_pct, input int stall_pct);
      @(negedge clock);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (n_items) queued_items.push_back(gen_item());
      wait_drained();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: refresh right after reset, limit edges, sample extremes
      add_item(FN_REFRESH, 32'd0, 7'h00);
      add_item(FN_CLEAR, 32'd0, 7'h7F);
      add_item(FN_TEMP, -32'sd40, 7'h00);
      add_item(FN_TEMP, -32'sd41, 7'h00);
      add_item(FN_TEMP, 32'sd85, 7'h00);
      add_item(FN_TEMP, 32'sd86, 7'h00);
      add_item(FN_VOLT, 32'd9000, 7'h00);
      add_item(FN_VOLT, 32'd8999, 7'h00);
      add_item(FN_VOLT, 32'd16001, 7'h00);
      add_item(FN_VOLT, 32'h8000_0000, 7'h00);
      add_item(FN_CURRENT, -32'sd10000, 7'h00);
      add_item(FN_CURRENT, 32'd10001, 7'h00);
      add_item(FN_CURRENT, 32'h8000_0000, 7'h00);
      add_item(FN_CURRENT, 32'h7FFF_FFFF, 7'h00);
      add_item(FN_TEMP, 32'h7FFF_FFFF, 7'h00);
      add_item(FN_VOLT, 32'hFFFF_FFFF, 7'h00);
      // range errors now at the limit, so the tick enters safe
      add_item(FN_TICK, 32'd0, 7'h00);
      add_item(FN_UNUSED, 32'hFFFF_FFFF, 7'h7F);
      add_item(FN_STATS, 32'd0, 7'h00);
      add_item(FN_CLEAR, 32'd0, 7'h00);
      add_item(FN_CLEAR, 32'd0, 7'h7F);
      add_item(FN_TICK, 32'd0, 7'h00);
      wait_drained();

      run_phase(230, 0, 0);
      set_config(2'd3, 32'd25, 32'd40, -16'sd20, 16'sd60, 16'd1000, 16'd2000, 31'd500);
      run_phase(240, 76, 0);
      set_config(2'd1, 32'd0, 32'd0, 16'h8000, 16'h7FFF, 16'd0, 16'hFFFF, 31'h7FFF_FFFF);
      run_phase(240, 0, 76);
      set_config(2'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h7FFF, 16'h8000, 16'hFFFF, 16'd0,
                 31'd0);
      run_phase(240, 6, 6);
      set_config(2'd0, 32'd5, 32'd5, 16'd0, 16'd0, 16'd0, 16'd0, 31'd0);
      pressure_go = 1'b1;
      run_phase(240, 0, 0);
      set_config(2'd3, 32'd15, 32'd20, -16'sd5, 16'sd5, 16'd100, 16'd140, 31'd50);
      run_phase(240, 76, 0);
      set_config(2'd3, 32'd1000, 32'd5000, -16'sd40, 16'sd85, 16'd9000, 16'd16000,
                 31'd10000);
      run_phase(240, 0, 76);
      set_config(2'd3, 32'd40, 32'd12, -16'sd100, -16'sd90, 16'd3000, 16'd3000, 31'd1);
      run_phase(240, 6, 6);

      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
